@@ rtl/ggt_pkg.sv @@
// Package for the greedy group transliterator: sizes, command and status codes.
// No dependencies.
`default_nettype none
package ggt_pkg;
  localparam int TableEntries = 64;
  localparam int MaxKeyBytes  = 4;
  localparam int MaxOutCodes  = 2;
  localparam logic [7:0] SPACE_CODE = 8'd32;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TEXT  = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  localparam logic [1:0] ST_CHAR   = 2'd0;
  localparam logic [1:0] ST_LOADED = 2'd1;
  localparam logic [1:0] ST_DUP    = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;
endpackage
`default_nettype wire

@@ rtl/ggt_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ggt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(Depth)-1:0] waddr,
  input  wire [Width-1:0]         wdata,
  input  wire [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]        rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/greedy_group_transliterator.sv @@
// Greedy longest-match transliterator top level.
// Steps: first-byte read, key scan of one entry a cycle, decide, then an entry write for
// a load or a code read for characters; a pushed-back byte is scanned a second time.
// One request at a time: a new request is taken only in idle.
// Reset: sweep the 256-entry first-byte length memory to zero first.
`default_nettype none
module greedy_group_transliterator #(
  parameter int TABLE_ENTRIES = ggt_pkg::TableEntries
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tuser fields from bit 0: cmd[1:0]
  input  wire  [1:0]  s_axis_tuser,
  // tdata fields from bit 0: key_byte0..3 [31:0], key_length[34:32], code_first[50:35],
  // code_second[66:51], code_count[68:67], text_byte[76:69]; zero padded to 80 bits
  input  wire  [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata fields from bit 0: code_point[15:0]
  output logic [15:0] m_axis_tdata,
  // tuser fields from bit 0: status[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import ggt_pkg::*;
  localparam int AW = $clog2(TABLE_ENTRIES) > 0 ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FBRD  = 4'd2;  // first-byte length read issued
  localparam logic [3:0] S_SCAN  = 4'd3;  // key scan
  localparam logic [3:0] S_DEC   = 4'd4;  // act on scan result
  localparam logic [3:0] S_CRD   = 4'd5;  // code read issued
  localparam logic [3:0] S_EMIT  = 4'd6;  // queue output
  localparam logic [3:0] S_OUT   = 4'd7;  // drain output queue
  localparam logic [3:0] S_FBWR  = 4'd8;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_EXT = 2'd2;

  logic [3:0] state;
  logic [1:0] op;
  logic [8:0] clr_cnt;
  logic [CW-1:0] entry_total;
  logic [31:0] pend;
  logic [2:0] pend_len;
  logic [AW-1:0] lm_entry;
  logic lm_valid;
  logic [7:0] byte_in;
  logic [31:0] key;
  logic [2:0] klen;
  logic [33:0] codes_in;
  logic [2:0] fbmax;
  logic replay;       // reprocess the byte after emitting
  logic [CW-1:0] scan_i;
  logic scan_rd;      // a read is in flight
  logic found;
  logic [AW-1:0] found_idx;
  // output queue of up to 4 results
  logic [17:0] q [4];
  logic [2:0] q_n, q_rd;

  wire [1:0] cmd = s_axis_tuser;
  wire s_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  // memories
  logic k_we, c_we, f_we;
  logic [34:0] k_rd;
  logic [33:0] c_rd;
  logic [2:0] f_rd, f_wd;
  logic [AW-1:0] k_ra, c_ra;
  logic [7:0] f_ra, f_wa;
  ggt_ram #(.Width(35), .Depth(TABLE_ENTRIES)) u_keys (.clk(clk), .we(k_we),
    .waddr(entry_total[AW-1:0]), .wdata({klen, key}), .raddr(k_ra), .rdata(k_rd));
  ggt_ram #(.Width(34), .Depth(TABLE_ENTRIES)) u_codes (.clk(clk), .we(c_we),
    .waddr(entry_total[AW-1:0]), .wdata(codes_in), .raddr(c_ra), .rdata(c_rd));
  ggt_ram #(.Width(3), .Depth(256)) u_fbl (.clk(clk), .we(f_we), .waddr(f_wa),
    .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  assign k_ra = scan_i[AW-1:0];
  // in idle, read the length of the byte that leads the group this request touches
  assign f_ra = (state == S_IDLE) ? (cmd == CMD_LOAD ? s_axis_tdata[7:0]
                : (pend_len != 3'd0 ? pend[7:0] : s_axis_tdata[76:69])) : byte_in;
  assign k_we = (state == S_FBWR);
  assign c_we = k_we;
  assign f_we = (state == S_CLR) || (state == S_FBWR && fbmax < klen);
  assign f_wa = (state == S_CLR) ? clr_cnt[7:0] : key[7:0];
  assign f_wd = (state == S_CLR) ? 3'd0 : klen;

  // masked key compare of a stored entry
  logic [31:0] kmask;
  always_comb begin
    unique case (klen)
      3'd1: kmask = 32'h0000_00ff;
      3'd2: kmask = 32'h0000_ffff;
      3'd3: kmask = 32'h00ff_ffff;
      default: kmask = 32'hffff_ffff;
    endcase
  end
  wire hit = (k_rd[34:32] == klen) && ((k_rd[31:0] & kmask) == (key & kmask));

  // clamp key length to 1..4 and code count to 1..2
  logic [1:0] cc_in;
  logic [2:0] kl_sat;
  always_comb begin
    kl_sat = s_axis_tdata[34:32];
    if (kl_sat == 3'd0) kl_sat = 3'd1;
    if (kl_sat > 3'd4) kl_sat = 3'd4;
    cc_in = s_axis_tdata[68:67] == 2'd0 ? 2'd1 : (s_axis_tdata[68:67] > 2'd2 ? 2'd2
            : s_axis_tdata[68:67]);
  end

  // emit codes of entry read into queue (valid in the cycle after S_CRD)
  logic emit_raw;     // emit pend byte 0 raw instead of entry codes
  logic emit_byte;    // emit byte_in raw
  logic after_emit_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_cnt <= '0; entry_total <= '0; pend_len <= '0;
      pend <= '0; lm_valid <= 1'b0; lm_entry <= '0; q_n <= '0; q_rd <= '0;
      m_axis_tvalid <= 1'b0; scan_rd <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 9'd1;
          if (clr_cnt == 9'd255) state <= S_IDLE;
        end
        S_IDLE: begin
          q_n <= '0; q_rd <= '0; replay <= 1'b0;
          if (s_acc) begin
            byte_in <= s_axis_tdata[76:69];
            codes_in <= {cc_in, s_axis_tdata[66:51], s_axis_tdata[50:35]};
            case (cmd)
              CMD_LOAD: begin
                op <= OP_LOAD; klen <= kl_sat; key <= s_axis_tdata[31:0];
                state <= S_FBRD;
              end
              CMD_TEXT: begin
                op <= (pend_len != 3'd0) ? OP_EXT : OP_START;
                state <= S_FBRD;
              end
              CMD_FLUSH: begin
                if (pend_len != 3'd0) begin
                  emit_raw <= !lm_valid; emit_byte <= 1'b0;
                  after_emit_clear <= 1'b1; state <= S_CRD;
                end
              end
              default: ;
            endcase
          end
        end
        S_FBRD: begin
          fbmax <= f_rd;
          scan_i <= '0; found <= 1'b0; scan_rd <= 1'b0;
          if (op == OP_START) begin
            key <= {24'd0, byte_in}; klen <= 3'd1;
            if (byte_in < SPACE_CODE || f_rd == 3'd0) begin
              emit_byte <= 1'b1; emit_raw <= 1'b0; replay <= 1'b0;
              after_emit_clear <= 1'b0; state <= S_CRD;
            end else state <= S_SCAN;
          end else if (op == OP_EXT) begin
            klen <= pend_len + 3'd1;
            unique case (pend_len)
              3'd1: key <= {16'd0, byte_in, pend[7:0]};
              3'd2: key <= {8'd0, byte_in, pend[15:0]};
              default: key <= {byte_in, pend[23:0]};
            endcase
            if (pend_len >= 3'd4) begin
              emit_raw <= !lm_valid; emit_byte <= 1'b0; after_emit_clear <= 1'b1;
              replay <= 1'b1; state <= S_CRD;
            end else state <= S_SCAN;
          end else state <= S_SCAN;
        end
        S_SCAN: begin
          // one entry a cycle; hit evaluated on the registered read
          if (scan_rd && hit && !found) begin
            found <= 1'b1; found_idx <= scan_i[AW-1:0] - AW'(1);
          end
          if (found || (scan_rd && hit) || scan_i >= entry_total) begin
            scan_rd <= 1'b0; state <= S_DEC;
          end else begin
            scan_rd <= 1'b1; scan_i <= scan_i + CW'(1);
          end
        end
        S_DEC: begin
          unique case (op)
            OP_LOAD: begin
              if (found) begin
                q[0] <= {ST_DUP, 16'd0}; q_n <= 3'd1; state <= S_OUT;
              end else if (CW'(TABLE_ENTRIES) <= entry_total) begin
                q[0] <= {ST_FULL, 16'd0}; q_n <= 3'd1; state <= S_OUT;
              end else state <= S_FBWR;
            end
            OP_START: begin
              if (fbmax <= 3'd1) begin
                lm_entry <= found_idx; emit_raw <= 1'b0; emit_byte <= !found;
                after_emit_clear <= 1'b0; state <= S_CRD;
              end else begin
                pend <= {24'd0, byte_in}; pend_len <= 3'd1;
                lm_valid <= found; lm_entry <= found ? found_idx : '0;
                state <= S_OUT;
              end
            end
            default: begin
              if (found && klen < fbmax) begin
                pend <= key; pend_len <= klen; lm_entry <= found_idx;
                lm_valid <= 1'b1; state <= S_OUT;
              end else if (found) begin
                lm_entry <= found_idx; emit_raw <= 1'b0; emit_byte <= 1'b0;
                after_emit_clear <= 1'b1; state <= S_CRD;
              end else begin
                // mismatch: emit the pending group, then push the byte back
                emit_raw <= !lm_valid; emit_byte <= 1'b0; after_emit_clear <= 1'b1;
                replay <= 1'b1; state <= S_CRD;
              end
            end
          endcase
        end
        S_CRD: state <= S_EMIT;  // c_rd valid next cycle
        S_EMIT: begin
          if (emit_byte) begin
            q[q_n[1:0]] <= {ST_CHAR, 8'd0, byte_in}; q_n <= q_n + 3'd1;
          end else if (emit_raw) begin
            q[q_n[1:0]] <= {ST_CHAR, 8'd0, pend[7:0]}; q_n <= q_n + 3'd1;
          end else begin
            q[q_n[1:0]] <= {ST_CHAR, c_rd[15:0]};
            if (c_rd[33:32] == 2'd2) begin
              q[q_n[1:0] + 2'd1] <= {ST_CHAR, c_rd[31:16]}; q_n <= q_n + 3'd2;
            end else q_n <= q_n + 3'd1;
          end
          if (after_emit_clear) begin
            pend <= '0; pend_len <= '0; lm_valid <= 1'b0; lm_entry <= '0;
          end
          if (replay) begin
            replay <= 1'b0; op <= OP_START; emit_byte <= 1'b0; emit_raw <= 1'b0;
            after_emit_clear <= 1'b0; state <= S_FBRD;
          end else state <= S_OUT;
        end
        S_FBWR: begin
          entry_total <= entry_total + CW'(1);
          q[0] <= {ST_LOADED, 16'd0}; q_n <= 3'd1; state <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tvalid && m_axis_tready) q_rd <= q_rd + 3'd1;
          if (q_rd == q_n || (m_axis_tvalid && m_axis_tready && q_rd + 3'd1 == q_n)) begin
            m_axis_tvalid <= 1'b0; state <= S_IDLE;
          end else m_axis_tvalid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign c_ra = lm_entry;
  logic [17:0] q_head;
  assign q_head = q[q_rd[1:0]];
  assign m_axis_tdata = q_head[15:0];
  assign m_axis_tuser = q_head[17:16];
  assign m_axis_tlast = (q_rd + 3'd1 == q_n);
endmodule
`default_nettype wire

@@ rtl/ggt_checker.sv @@
// Port-level checker for greedy_group_transliterator, bound to the top level.
// Depends on ggt_pkg and the top-level ports.
`default_nettype none
module ggt_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [15:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser,
  input wire        m_axis_tlast
);
  import ggt_pkg::*;
  // no new request while results are pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("request taken during output");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
    $stable({m_axis_tuser, m_axis_tdata, m_axis_tlast}))
    else $error("result changed under stall");
  // status results carry code zero and are last
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_CHAR |-> m_axis_tdata == 16'd0 &&
    m_axis_tlast) else $error("bad status result");
endmodule

bind greedy_group_transliterator ggt_checker u_ggt_checker (.*);
`default_nettype wire
